@@ hw/rtl/rmeu_pkg.sv @@
`default_nettype none
package rmeu_pkg;
  localparam int RegLimit  = 512;
  localparam int DataWidth = 32;
  localparam int AddrWidth = 9;
  localparam int RamDepth  = RegLimit - 2;

  typedef enum logic [4:0] {
    OP_INP = 5'd0, OP_PRT = 5'd1, OP_JMP = 5'd2, OP_JEQ = 5'd3, OP_JNE = 5'd4,
    OP_JGE = 5'd5, OP_JNG = 5'd6, OP_JLT = 5'd7, OP_JNL = 5'd8, OP_MOV = 5'd9,
    OP_ADD = 5'd10, OP_SUB = 5'd11, OP_MUL = 5'd12, OP_DIV = 5'd13,
    OP_MOD = 5'd14, OP_CMP = 5'd15, OP_LD = 5'd16, OP_STP = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_PROT = 3'd1, FLT_RANGE = 3'd2, FLT_NEGJ = 3'd3,
    FLT_OPC = 3'd4, FLT_DIV0 = 3'd5
  } fault_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_WB, ST_OUT
  } state_e;

  // Decoded word handed from the front end to the back end.
  typedef struct packed {
    logic [4:0]  op;
    logic [15:0] a1;
    logic [15:0] a2;
    logic [15:0] con;
    logic [2:0]  pre_fault;
    logic [15:0] pc_len;
  } dec_t;

  // Reset value of one register address.
  function automatic logic [DataWidth-1:0] init_val(input logic [AddrWidth-1:0] a);
    logic [DataWidth-1:0] v;
    v = '0;
    if (a == 9'd491) v = DataWidth'(10);
    else if (a >= 9'd432 && a <= 9'd490) v = DataWidth'(a - 9'd400);
    return v;
  endfunction

  // 0 ok, 1 protected, 2 out of range.
  function automatic logic [2:0] addr_chk(input logic [15:0] a);
    logic [2:0] f;
    f = FLT_NONE;
    if (a[15] || a <= 16'd1) f = FLT_PROT;
    else if (a >= 16'(RegLimit)) f = FLT_RANGE;
    return f;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/rmeu_ram.sv @@
`default_nettype none
module rmeu_ram #(
  parameter int Width = 32,
  parameter int Depth = 510
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/rmeu_front.sv @@
`default_nettype none
module rmeu_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire logic [4:0]       mode_i,
  input  wire logic [15:0]      first_arg_i,
  input  wire logic [15:0]      second_arg_i,
  input  wire logic [15:0]      console_value_i,
  output logic                  q_valid_o,
  output rmeu_pkg::dec_t        q_data_o,
  input  wire logic             q_pop_i
);
  // Two-entry queue of classified words.
  rmeu_pkg::dec_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push;
  rmeu_pkg::dec_t dec;

  always_comb begin
    dec.op = mode_i;
    dec.a1 = first_arg_i;
    dec.a2 = second_arg_i;
    dec.con = console_value_i;
    dec.pre_fault = rmeu_pkg::FLT_NONE;
    if (mode_i == rmeu_pkg::OP_STP) dec.pc_len = 16'd1;
    else if (mode_i >= rmeu_pkg::OP_MOV && mode_i <= rmeu_pkg::OP_LD) dec.pc_len = 16'd5;
    else dec.pc_len = 16'd3;
    if (mode_i > rmeu_pkg::OP_STP) dec.pre_fault = rmeu_pkg::FLT_OPC;
    else if (mode_i >= rmeu_pkg::OP_JMP && mode_i <= rmeu_pkg::OP_JNL && first_arg_i[15])
      dec.pre_fault = rmeu_pkg::FLT_NEGJ;
  end

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i && q_valid_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (q_pop_i && q_valid_o) rp_q <= ~rp_q;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rmeu_div.sv @@
`default_nettype none
module rmeu_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dvd_i,
  input  wire logic [31:0] dvs_i,
  output logic             done_o,
  output logic [31:0]      quo_o,
  output logic [31:0]      rem_o
);
  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [31:0] q_q, q_d, m_q, m_d, r_q, r_d;
  logic [5:0]  n_q, n_d;
  logic        busy_q, busy_d, nd_q, ns_q;
  logic [32:0] trial;

  always_comb begin
    q_d = q_q; m_d = m_q; r_d = r_q; n_d = n_q; busy_d = busy_q;
    trial = {r_q, q_q[31]} - {1'b0, m_q};
    if (start_i) begin
      q_d = dvd_i[31] ? 32'(-dvd_i) : dvd_i;
      m_d = dvs_i[31] ? 32'(-dvs_i) : dvs_i;
      r_d = '0; n_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) r_d = trial[31:0];
      else r_d = {r_q[30:0], q_q[31]};
      q_d = {q_q[30:0], !trial[32]};
      n_d = n_q - 6'd1;
      if (n_q == 6'd1) busy_d = 1'b0;
    end
  end

  assign done_o = busy_q && (n_q == 6'd1);
  assign quo_o  = (nd_q != ns_q) ? 32'(-q_q) : q_q;
  assign rem_o  = nd_q ? 32'(-r_q) : r_q;

  always_ff @(posedge clk_i) begin
    q_q <= q_d; m_q <= m_d; r_q <= r_d;
    if (start_i) begin nd_q <= dvd_i[31]; ns_q <= dvs_i[31]; end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; n_q <= '0;
    end else begin
      busy_q <= busy_d; n_q <= n_d;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rmeu_back.sv @@
`default_nettype none
module rmeu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire rmeu_pkg::dec_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output logic [15:0]          next_pc_o,
  output logic                 print_valid_o,
  output logic [8:0]           print_address_o,
  output logic [31:0]          print_value_o,
  output logic [2:0]           flag_bits_o,
  output logic                 halted_o,
  output logic [2:0]           fault_code_o
);
  rmeu_pkg::state_e st_q, st_d;
  rmeu_pkg::dec_t   it_q, it_d;
  logic [15:0] pc_q, pc_d;
  logic [2:0]  fl_q, fl_d;
  logic        stop_q, stop_d;
  logic [31:0] s_q, s_d, res_q, res_d, mul_q, mul_d;
  logic [2:0]  flt_q, flt_d;
  logic        pv_q, pv_d;
  logic [rmeu_pkg::AddrWidth-1:0] clr_q, clr_d;
  logic        ov_q, ov_d;

  logic          we;
  logic [rmeu_pkg::AddrWidth-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          dstart, ddone;
  logic [31:0]   quo, rem;
  logic [2:0]    f1, f2;
  logic          take;

  rmeu_ram #(.Width(32), .Depth(rmeu_pkg::RamDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  rmeu_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dvd_i(rdata), .dvs_i(s_q),
    .done_o(ddone), .quo_o(quo), .rem_o(rem)
  );

  assign f1 = rmeu_pkg::addr_chk(it_q.a1);
  assign f2 = rmeu_pkg::addr_chk(it_q.a2);

  always_comb begin
    case (it_q.op)
      rmeu_pkg::OP_JMP: take = 1'b1;
      rmeu_pkg::OP_JEQ: take = fl_q[0];
      rmeu_pkg::OP_JNE: take = !fl_q[0];
      rmeu_pkg::OP_JGE: take = fl_q[1];
      rmeu_pkg::OP_JNG: take = !fl_q[1];
      rmeu_pkg::OP_JLT: take = fl_q[2];
      rmeu_pkg::OP_JNL: take = !fl_q[2];
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    st_d = st_q; it_d = it_q; pc_d = pc_q; fl_d = fl_q; stop_d = stop_q;
    s_d = s_q; res_d = res_q; mul_d = mul_q; flt_d = flt_q; pv_d = pv_q;
    clr_d = clr_q; ov_d = ov_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0; dstart = 1'b0; q_pop_o = 1'b0;
    mul_d = 32'(rdata * s_q);
    if (ov_q && !stall_i) ov_d = 1'b0;
    case (st_q)
      rmeu_pkg::ST_INIT: begin
        we = 1'b1; waddr = clr_q;
        wdata = rmeu_pkg::init_val(9'(clr_q + rmeu_pkg::AddrWidth'(2)));
        clr_d = clr_q + rmeu_pkg::AddrWidth'(1);
        if (clr_q == rmeu_pkg::AddrWidth'(rmeu_pkg::RamDepth - 1)) st_d = rmeu_pkg::ST_IDLE;
      end
      rmeu_pkg::ST_IDLE: begin
        if (q_valid_i && !ov_q) begin
          q_pop_o = 1'b1; it_d = q_data_i; pv_d = 1'b0; res_d = '0;
          flt_d = rmeu_pkg::FLT_NONE;
          st_d = stop_q ? rmeu_pkg::ST_OUT : rmeu_pkg::ST_RD1;
        end
      end
      rmeu_pkg::ST_RD1: begin
        // Classify faults; issue the source read.
        pc_d = pc_q + it_q.pc_len;
        raddr = rmeu_pkg::AddrWidth'(it_q.a1 - 16'd2);
        st_d = rmeu_pkg::ST_WB;
        if (it_q.pre_fault != rmeu_pkg::FLT_NONE) begin
          flt_d = it_q.pre_fault;
        end else if (it_q.op == rmeu_pkg::OP_STP) begin
          stop_d = 1'b1;
        end else if (it_q.op >= rmeu_pkg::OP_JMP && it_q.op <= rmeu_pkg::OP_JNL) begin
          if (take) pc_d = it_q.a1;
        end else if (it_q.op == rmeu_pkg::OP_LD) begin
          if (f2 != rmeu_pkg::FLT_NONE) flt_d = f2;
          else begin
            we = 1'b1; waddr = rmeu_pkg::AddrWidth'(it_q.a2 - 16'd2);
            wdata = 32'(signed'(it_q.a1));
          end
        end else if (it_q.op <= rmeu_pkg::OP_PRT) begin
          if (f1 != rmeu_pkg::FLT_NONE) flt_d = f1;
          else if (it_q.op == rmeu_pkg::OP_INP) begin
            we = 1'b1; waddr = rmeu_pkg::AddrWidth'(it_q.a1 - 16'd2);
            wdata = 32'(signed'(it_q.con));
          end else st_d = rmeu_pkg::ST_EXEC;
        end else begin
          if (f1 != rmeu_pkg::FLT_NONE) flt_d = f1;
          else if (f2 != rmeu_pkg::FLT_NONE) flt_d = f2;
          else st_d = rmeu_pkg::ST_RD2;
        end
      end
      rmeu_pkg::ST_RD2: begin
        s_d = rdata;
        raddr = rmeu_pkg::AddrWidth'(it_q.a2 - 16'd2);
        st_d = rmeu_pkg::ST_EXEC;
      end
      rmeu_pkg::ST_EXEC: begin
        st_d = rmeu_pkg::ST_WB;
        case (it_q.op)
          rmeu_pkg::OP_PRT: begin pv_d = 1'b1; res_d = rdata; end
          rmeu_pkg::OP_MOV: res_d = s_q;
          rmeu_pkg::OP_ADD: res_d = rdata + s_q;
          rmeu_pkg::OP_SUB: res_d = rdata - s_q;
          rmeu_pkg::OP_MUL: st_d = rmeu_pkg::ST_DIV;
          rmeu_pkg::OP_DIV, rmeu_pkg::OP_MOD: begin
            if (s_q == '0) flt_d = rmeu_pkg::FLT_DIV0;
            else begin dstart = 1'b1; st_d = rmeu_pkg::ST_DIV; end
          end
          rmeu_pkg::OP_CMP: begin
            fl_d = {($signed(s_q) < $signed(rdata)), ($signed(rdata) < $signed(s_q)),
                    (s_q == rdata)};
          end
          default: ;
        endcase
      end
      rmeu_pkg::ST_DIV: begin
        if (it_q.op == rmeu_pkg::OP_MUL) begin
          res_d = mul_q; st_d = rmeu_pkg::ST_WB;
        end else if (ddone) begin
          st_d = rmeu_pkg::ST_WB;
        end
      end
      rmeu_pkg::ST_WB: begin
        if (it_q.op == rmeu_pkg::OP_DIV) res_d = quo;
        else if (it_q.op == rmeu_pkg::OP_MOD) res_d = rem;
        if (flt_q != rmeu_pkg::FLT_NONE) stop_d = 1'b1;
        st_d = rmeu_pkg::ST_OUT;
      end
      rmeu_pkg::ST_OUT: begin
        if (flt_q == rmeu_pkg::FLT_NONE && it_q.op >= rmeu_pkg::OP_MOV &&
            it_q.op <= rmeu_pkg::OP_MOD && !stop_q) begin
          we = 1'b1; waddr = rmeu_pkg::AddrWidth'(it_q.a2 - 16'd2); wdata = res_q;
        end
        ov_d = 1'b1;
        st_d = rmeu_pkg::ST_IDLE;
      end
      default: st_d = rmeu_pkg::ST_IDLE;
    endcase
  end

  // Result register: loaded in ST_OUT, held while the sink stalls.
  logic [15:0] opc_q;
  logic        opv_q, oh_q;
  logic [8:0]  opa_q;
  logic [31:0] opval_q;
  logic [2:0]  ofl_q, oflt_q;
  logic        was_stop;
  assign was_stop = (st_q == rmeu_pkg::ST_OUT) && stop_q && (flt_q == rmeu_pkg::FLT_NONE)
                    && (it_q.op != rmeu_pkg::OP_STP);

  always_ff @(posedge clk_i) begin
    if (st_q == rmeu_pkg::ST_OUT) begin
      opc_q   <= pc_q;
      opv_q   <= pv_q && !was_stop;
      opa_q   <= pv_q && !was_stop ? it_q.a1[8:0] : 9'd0;
      opval_q <= pv_q && !was_stop ? res_q : 32'd0;
      ofl_q   <= fl_q;
      oh_q    <= stop_q;
      oflt_q  <= was_stop ? rmeu_pkg::FLT_NONE : flt_q;
    end
    it_q <= it_d; s_q <= s_d; res_q <= res_d; mul_q <= mul_d; flt_q <= flt_d; pv_q <= pv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rmeu_pkg::ST_INIT; pc_q <= '0; fl_q <= '0; stop_q <= 1'b0;
      clr_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; fl_q <= fl_d; stop_q <= stop_d;
      clr_q <= clr_d; ov_q <= ov_d;
    end
  end

  assign valid_o         = ov_q;
  assign next_pc_o       = opc_q;
  assign print_valid_o   = opv_q;
  assign print_address_o = opa_q;
  assign print_value_o   = opval_q;
  assign flag_bits_o     = ofl_q;
  assign halted_o        = oh_q;
  assign fault_code_o    = oflt_q;
endmodule
`default_nettype wire

@@ hw/rtl/register_machine_execute_unit_top.sv @@
`default_nettype none
// Execute unit of a small register machine. Each input word is one decoded
// instruction; each produces exactly one output word carrying the new program
// counter, print data, flags, halt status and fault code. After reset the
// unit loads the register file with its initial contents (ASCII codes in
// addresses 432 to 491) and takes no instruction in that time; the front
// queue may still accept two words. The back end handles one word at a time
// and takes the next only after the previous output word has left. Jumps,
// load immediate, input, stop and faults found at decode pass through ST_RD1,
// ST_WB and ST_OUT; print adds ST_EXEC; move, add, subtract and compare add
// ST_RD2 as well, set by the separate reads of source and destination through
// the one read port of the register file memory and the write-back; multiply,
// divide and modulo also pass through ST_DIV, where divide and modulo wait for
// the bit-serial divider. Once halted by stop or a fault, every later word
// returns the held state with halted set.
module register_machine_execute_unit_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [4:0]  mode_i,
  input  wire logic [15:0] first_arg_i,
  input  wire logic [15:0] second_arg_i,
  input  wire logic [15:0] console_value_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [15:0]      next_pc_o,
  output logic             print_valid_o,
  output logic [8:0]       print_address_o,
  output logic [31:0]      print_value_o,
  output logic [2:0]       flag_bits_o,
  output logic             halted_o,
  output logic [2:0]       fault_code_o
);
  // Words queued by the front end for the back end.
  logic           q_valid, q_pop;
  rmeu_pkg::dec_t q_data;

  rmeu_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .first_arg_i, .second_arg_i,
    .console_value_i, .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  rmeu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .valid_o, .stall_i, .next_pc_o, .print_valid_o, .print_address_o,
    .print_value_o, .flag_bits_o, .halted_o, .fault_code_o
  );
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the register machine execute unit. A directed table of
// instructions is sent first, followed by random well-formed programs. A
// behavioral model of the unit runs in the testbench and predicts every
// output word. Because a fault or a stop halts the unit for good, and reset is
// applied only once, the run ends with a single randomly chosen halting
// instruction and a few words sent while the unit is halted.
module tb_top;
  import rmeu_pkg::*;

  localparam int WatchdogLimit = 6000;

  typedef struct {
    logic [4:0]  mode;
    logic [15:0] a1;
    logic [15:0] a2;
    logic [15:0] con;
  } instr_t;

  typedef struct {
    logic [15:0] pc;
    logic        pv;
    logic [8:0]  pa;
    logic [31:0] pval;
    logic [2:0]  flg;
    logic        halt;
    logic [2:0]  fault;
  } outcome_t;

  // A directed row may carry its expected word typed in by hand.
  typedef struct {
    instr_t   ins;
    bit       typed;
    outcome_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [4:0]  mode_i = '0;
  logic [15:0] first_arg_i = '0;
  logic [15:0] second_arg_i = '0;
  logic [15:0] console_value_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [15:0] next_pc_o;
  logic        print_valid_o;
  logic [8:0]  print_address_o;
  logic [31:0] print_value_o;
  logic [2:0]  flag_bits_o;
  logic        halted_o;
  logic [2:0]  fault_code_o;

  register_machine_execute_unit_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the architectural state of the unit.
  logic signed [31:0] shadow_regs [2:511];
  logic [2:0]         shadow_flags;
  logic [15:0]        shadow_pc;
  bit                 shadow_halt;

  outcome_t pending_words[$];
  int       errors = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       quiet_cycles = 0;

  // Returns 0 for a usable register address, else the fault it raises.
  function automatic logic [2:0] reg_fault(logic [15:0] a);
    if ($signed(a) <= 1) return FLT_PROT;
    if ($signed(a) >= 512) return FLT_RANGE;
    return FLT_NONE;
  endfunction

  // Executes one instruction on the shadow state and returns the word the
  // unit must produce for it.
  function automatic outcome_t execute(instr_t ins);
    outcome_t r;
    logic [2:0] f;
    bit take;
    longint s, d, q;
    r = '{default: '0};
    if (shadow_halt) begin
      r.pc = shadow_pc;
      r.flg = shadow_flags;
      r.halt = 1'b1;
      return r;
    end
    f = FLT_NONE;
    if (ins.mode == OP_STP) r.pc = shadow_pc + 16'd1;
    else if (ins.mode >= OP_MOV && ins.mode <= OP_LD) r.pc = shadow_pc + 16'd5;
    else r.pc = shadow_pc + 16'd3;
    if (ins.mode <= OP_PRT) begin
      f = reg_fault(ins.a1);
      if (f == FLT_NONE) begin
        if (ins.mode == OP_INP) begin
          shadow_regs[ins.a1] = 32'(signed'(ins.con));
        end else begin
          r.pv = 1'b1;
          r.pa = ins.a1[8:0];
          r.pval = shadow_regs[ins.a1];
        end
      end
    end else if (ins.mode <= OP_JNL) begin
      if (ins.a1[15]) begin
        f = FLT_NEGJ;
      end else begin
        case (ins.mode)
          OP_JMP: take = 1'b1;
          OP_JEQ: take = shadow_flags[0];
          OP_JNE: take = !shadow_flags[0];
          OP_JGE: take = shadow_flags[1];
          OP_JNG: take = !shadow_flags[1];
          OP_JLT: take = shadow_flags[2];
          default: take = !shadow_flags[2];
        endcase
        if (take) r.pc = ins.a1;
      end
    end else if (ins.mode == OP_LD) begin
      f = reg_fault(ins.a2);
      if (f == FLT_NONE) shadow_regs[ins.a2] = 32'(signed'(ins.a1));
    end else if (ins.mode <= OP_CMP) begin
      f = reg_fault(ins.a1);
      if (f == FLT_NONE) f = reg_fault(ins.a2);
      if (f == FLT_NONE) begin
        s = shadow_regs[ins.a1];
        d = shadow_regs[ins.a2];
        q = d;
        case (ins.mode)
          OP_MOV: q = s;
          OP_ADD: q = d + s;
          OP_SUB: q = d - s;
          OP_MUL: q = d * s;
          OP_DIV, OP_MOD: begin
            // Done in 64 bits so that the most negative value over -1 wraps.
            if (s == 0) f = FLT_DIV0;
            else q = (ins.mode == OP_DIV) ? d / s : d % s;
          end
          default: shadow_flags = {s < d, d < s, s == d};
        endcase
        if (f == FLT_NONE && ins.mode != OP_CMP) shadow_regs[ins.a2] = q[31:0];
      end
    end else if (ins.mode == OP_STP) begin
      shadow_halt = 1'b1;
    end else begin
      f = FLT_OPC;
    end
    if (f != FLT_NONE) shadow_halt = 1'b1;
    shadow_pc = r.pc;
    r.flg = shadow_flags;
    r.halt = shadow_halt;
    r.fault = f;
    return r;
  endfunction

  // Presents one word after a random idle gap and holds it until taken. The
  // expected word is queued at the edge that accepts it.
  task automatic send(instr_t ins, bit typed = 1'b0, outcome_t want = '{default: '0});
    outcome_t r;
    while ($urandom_range(99) < idle_pct) begin
      valid_i = 1'b0;
      @(negedge clk_i);
    end
    valid_i = 1'b1;
    mode_i = ins.mode;
    first_arg_i = ins.a1;
    second_arg_i = ins.a2;
    console_value_i = ins.con;
    do @(posedge clk_i); while (stall_o);
    r = execute(ins);
    pending_words.push_back(typed ? want : r);
    @(negedge clk_i);
    valid_i = 1'b0;
  endtask

  // Favors a few low registers so values get reused, with some picks among
  // the preloaded character codes and across the whole file.
  function automatic logic [15:0] pick_reg();
    int k;
    k = $urandom_range(99);
    if (k < 60) return 16'($urandom_range(2, 9));
    if (k < 80) return 16'($urandom_range(430, 495));
    return 16'($urandom_range(2, 511));
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    ins.mode = 5'($urandom_range(0, 16));
    ins.a1 = pick_reg();
    ins.a2 = 16'($urandom);
    ins.con = 16'($urandom);
    if (ins.mode >= OP_JMP && ins.mode <= OP_JNL) ins.a1 = 16'($urandom_range(0, 32767));
    if (ins.mode >= OP_MOV) ins.a2 = pick_reg();
    if (ins.mode == OP_LD) ins.a1 = 16'($urandom);
    // A zero divisor would halt the unit, so that case is left to the end.
    if ((ins.mode == OP_DIV || ins.mode == OP_MOD) && shadow_regs[ins.a1] == 0)
      ins.mode = OP_ADD;
    return ins;
  endfunction

  // Receiver side: random stall, changed on the falling edge.
  always @(negedge clk_i) stall_i <= ($urandom_range(99) < stall_pct);

  // Output checker and watchdog.
  always @(posedge clk_i) begin
    outcome_t w;
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (next_pc_o !== w.pc) begin
          $error("next_pc exp %0d got %0d", w.pc, next_pc_o); errors++;
        end
        if (print_valid_o !== w.pv) begin
          $error("print_valid exp %0d got %0d", w.pv, print_valid_o); errors++;
        end
        if (print_address_o !== w.pa) begin
          $error("print_address exp %0d got %0d", w.pa, print_address_o); errors++;
        end
        if (print_value_o !== w.pval) begin
          $error("print_value exp %h got %h", w.pval, print_value_o); errors++;
        end
        if (flag_bits_o !== w.flg) begin
          $error("flag_bits exp %b got %b", w.flg, flag_bits_o); errors++;
        end
        if (halted_o !== w.halt) begin
          $error("halted exp %0d got %0d", w.halt, halted_o); errors++;
        end
        if (fault_code_o !== w.fault) begin
          $error("fault_code exp %0d got %0d", w.fault, fault_code_o); errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    instr_t ins;
    int kind;
    outcome_t tw;
    for (int i = 2; i <= 511; i++)
      shadow_regs[i] = (i == 491) ? 10 : (i >= 432 && i <= 490) ? i - 400 : 0;
    shadow_flags = '0;
    shadow_pc = '0;
    shadow_halt = 1'b0;

    // Reset contents are visible right away: prints of preloaded and empty
    // registers, with the program counter stepping by three.
    tw = '{default: '0};
    tw.pv = 1'b1;
    tw.pc = 16'd3; tw.pa = 9'd432; tw.pval = 32;
    rows.push_back('{'{OP_PRT, 16'd432, 16'hFFFF, 16'd0}, 1'b1, tw});
    tw.pc = 16'd6; tw.pa = 9'd491; tw.pval = 10;
    rows.push_back('{'{OP_PRT, 16'd491, 16'h8000, 16'd0}, 1'b1, tw});
    tw.pc = 16'd9; tw.pa = 9'd511; tw.pval = 0;
    rows.push_back('{'{OP_PRT, 16'd511, 16'd0, 16'h7FFF}, 1'b1, tw});
    // Immediate and console extremes, then every arithmetic operation,
    // including signed divide and modulo and a multiply of -1 by -1.
    rows.push_back('{'{OP_LD, 16'h7FFF, 16'd2, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_LD, 16'h8000, 16'd3, 16'hFFFF}, 1'b0, tw});
    rows.push_back('{'{OP_INP, 16'd511, 16'd0, 16'hFFFF}, 1'b0, tw});
    rows.push_back('{'{OP_INP, 16'd4, 16'h7FFF, 16'h7FFF}, 1'b0, tw});
    rows.push_back('{'{OP_INP, 16'd5, 16'h1234, 16'h8000}, 1'b0, tw});
    rows.push_back('{'{OP_ADD, 16'd2, 16'd3, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_SUB, 16'd3, 16'd4, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_MUL, 16'd511, 16'd511, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_MUL, 16'd2, 16'd4, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_DIV, 16'd433, 16'd5, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_MOD, 16'd437, 16'd3, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_MOV, 16'd490, 16'd6, 16'd0}, 1'b0, tw});
    // Compare then every conditional jump, taken or not, targets at both ends.
    rows.push_back('{'{OP_CMP, 16'd2, 16'd3, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JGE, 16'd0, 16'd0, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JNG, 16'd100, 16'd0, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JLT, 16'h7FFF, 16'd0, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JNL, 16'd5, 16'd0, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_CMP, 16'd6, 16'd6, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JEQ, 16'd10, 16'd0, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JNE, 16'd20, 16'd0, 16'd0}, 1'b0, tw});
    rows.push_back('{'{OP_JMP, 16'd0, 16'd0, 16'd0}, 1'b0, tw});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send(rows[i].ins, rows[i].typed, rows[i].want);

    // Random programs in four traffic phases: free flow, a slow sender, a
    // slow receiver, and both slow.
    for (int n = 0; n < 500; n++) begin
      case (n / 125)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 67; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 67; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      // Let the unit drain completely once before carrying on.
      if (n == 300) begin
        wait (pending_words.size() == 0);
        @(negedge clk_i);
      end
      send(random_instr());
    end

    // One halting instruction of a random kind, then words that the halted
    // unit must answer with its held state.
    ins = '{OP_STP, 16'($urandom), 16'($urandom), 16'($urandom)};
    kind = $urandom_range(0, 5);
    case (kind)
      1: ins.mode = 5'($urandom_range(18, 31));
      2: begin
        ins.mode = 5'($urandom_range(OP_JMP, OP_JNL));
        ins.a1 = 16'($urandom_range(32768, 65535));
      end
      3: begin
        ins.mode = OP_PRT;
        ins.a1 = ($urandom_range(1)) ? 16'($urandom_range(0, 1)) : 16'hFFFF;
      end
      4: begin
        ins.mode = 5'($urandom_range(OP_MOV, OP_CMP));
        ins.a1 = pick_reg();
        ins.a2 = 16'($urandom_range(512, 32767));
      end
      5: begin
        send('{OP_LD, 16'd0, 16'd2, 16'd0});
        ins = '{OP_DIV, 16'd2, 16'd3, 16'd0};
        if ($urandom_range(1)) ins.mode = OP_MOD;
      end
      default: ;
    endcase
    send(ins);
    repeat (3) send(random_instr());

    wait (pending_words.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
